@@ rtl/core/steering_pulse_law_unit_macros.svh @@
// ----------------------------------------------------------------------------
// steering pulse law unit assertion macros
// short forms for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef STEERING_PULSE_LAW_UNIT_MACROS_SVH
`define STEERING_PULSE_LAW_UNIT_MACROS_SVH

`ifndef SYNTH
// antecedent in this cycle implies consequent in this cycle
`define SPL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// antecedent in this cycle implies consequent in the next cycle
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define SPL_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// shared types, constants and the arctangent table of the steering pulse law
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

  // cordic datapath
  localparam int CORDIC_STEPS = 28;
  localparam int CW           = 34;
  localparam int STEP_W       = 5;

  localparam logic [31:0]          DEG_TO_TURN     = 32'd3054198966;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic [28:0]          LOOK_SCALE      = 29'd102400;

  // output constants
  localparam logic [12:0] TURN_LIMIT = 13'd4000;
  localparam logic [13:0] RUN_SPEED  = 14'd11000;

  // register indexes
  localparam logic [1:0] CFG_LOOKAHEAD  = 2'd0;
  localparam logic [1:0] CFG_GAIN       = 2'd1;
  localparam logic [1:0] CFG_ANGLE_OFS  = 2'd2;
  localparam logic [1:0] CFG_DIST_OFS   = 2'd3;

  // beat travelling through a cordic cell
  typedef struct packed {
    logic                 go;
    logic [31:0]          tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] a;
    a = 32'h0;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/spl_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// spl_cordic_cell
// one registered cordic micro-rotation, vectoring or rotation mode
// ----------------------------------------------------------------------------
`default_nettype none

module spl_cordic_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [spl_pkg::STEP_W-1:0]  step,
  input  wire logic                        vectoring,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire spl_pkg::cordic_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output spl_pkg::cordic_t                 out_data
);
  import spl_pkg::*;

  logic                 plus;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] ang;
  cordic_t              data_next;

  // direction: both modes turn the same way on this condition
  always_comb begin
    xs   = in_data.x >>> step;
    ys   = in_data.y >>> step;
    ang  = $signed({2'b00, atan_turn(step)});
    plus = vectoring ? (in_data.y > 0) : (in_data.z < 0);
    data_next     = in_data;
    if (plus) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ang;
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ang;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/spl_pulse_law.sv @@
// ----------------------------------------------------------------------------
// spl_pulse_law
// gain, deadband, cubic pulse law, scaling by 1/1000 and clamp
// ----------------------------------------------------------------------------
`default_nettype none

module spl_pulse_law (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [15:0]                   steer_gain,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_go,
  input  wire logic signed [spl_pkg::CW-1:0] in_sin,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [12:0]                 out_turn,
  output logic                               out_go
);
  import spl_pkg::*;

  localparam int NST = 7;
  localparam logic [49:0] DEAD_MAX = 50'((64'd3 << 42) / 64'd100);
  localparam logic [24:0] U_ONE    = 25'd16777216;
  localparam logic [27:0] C3       = 28'd164977000;
  localparam logic signed [29:0] C2 = 30'sd71145760;
  localparam logic signed [29:0] C1 = 30'sd24997900;
  localparam logic signed [29:0] C0 = 30'sd945076;
  localparam logic [27:0] RECIP_1000 = 28'd137438954;

  logic [NST-1:0] pv;
  logic [NST-1:0] pr;

  // stage registers
  logic                 go0, go1, go2, go3, go4, go5;
  logic                 neg1, neg2, neg3, neg4, neg5;
  logic                 dead1, dead2, dead3, dead4, dead5;
  logic signed [50:0]   w0;
  logic [24:0]          u1, u2, u3;
  logic signed [29:0]   acc2, acc3, acc4;
  logic [54:0]          q5;

  // combinational helpers
  logic [49:0]          mag;
  logic [31:0]          ush;
  logic [52:0]          t3;
  logic signed [55:0]   p2;
  logic signed [55:0]   p3;
  logic [26:0]          apos;
  logic [17:0]          mg;
  logic [12:0]          lim;

  // ready ripples back from the output register
  always_comb begin
    pr[NST-1] = !pv[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      pr[k] = !pv[k] || pr[k+1];
    end
  end
  assign in_ready  = pr[0];
  assign out_valid = pv[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      if (pr[0]) begin
        pv[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (pr[k]) begin
          pv[k] <= pv[k-1];
        end
      end
    end
  end

  // magnitude, deadband and horner arithmetic
  always_comb begin
    mag  = w0[50] ? 50'(-w0) : 50'(w0);
    ush  = mag[49:18];
    t3   = 53'(C3) * 53'(u1);
    p2   = acc2 * $signed({1'b0, u2});
    p3   = acc3 * $signed({1'b0, u3});
    apos = acc4[29] ? 27'd0 : acc4[26:0];
    mg   = q5[54:37];
    lim  = (mg > 18'(TURN_LIMIT)) ? TURN_LIMIT : mg[12:0];
  end

  // gain stage
  always_ff @(posedge clk) begin
    if (pr[0] && in_valid) begin
      go0 <= in_go;
      w0  <= $signed({1'b0, steer_gain}) * in_sin;
    end
  end

  // deadband and unit-range input
  always_ff @(posedge clk) begin
    if (pr[1] && pv[0]) begin
      go1   <= go0;
      neg1  <= w0[50];
      dead1 <= (mag <= DEAD_MAX);
      u1    <= (ush > 32'(U_ONE)) ? U_ONE : ush[24:0];
    end
  end

  // cubic term
  always_ff @(posedge clk) begin
    if (pr[2] && pv[1]) begin
      go2   <= go1;
      neg2  <= neg1;
      dead2 <= dead1;
      u2    <= u1;
      acc2  <= $signed({1'b0, t3[52:24]}) - C2;
    end
  end

  // square term
  always_ff @(posedge clk) begin
    if (pr[3] && pv[2]) begin
      go3   <= go2;
      neg3  <= neg2;
      dead3 <= dead2;
      u3    <= u2;
      acc3  <= p2[53:24] + C1;
    end
  end

  // linear term
  always_ff @(posedge clk) begin
    if (pr[4] && pv[3]) begin
      go4   <= go3;
      neg4  <= neg3;
      dead4 <= dead3;
      acc4  <= p3[53:24] + C0;
    end
  end

  // divide by 1000 through the reciprocal
  always_ff @(posedge clk) begin
    if (pr[5] && pv[4]) begin
      go5   <= go4;
      neg5  <= neg4;
      dead5 <= dead4;
      q5    <= 55'(apos) * 55'(RECIP_1000);
    end
  end

  // negate, clamp and output register
  always_ff @(posedge clk) begin
    if (pr[6] && pv[5]) begin
      out_go <= go5;
      if (!go5 || dead5) begin
        out_turn <= '0;
      end else if (neg5) begin
        out_turn <= $signed(lim);
      end else begin
        out_turn <= -$signed(lim);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/steering_pulse_law_unit.sv @@
// ----------------------------------------------------------------------------
// steering_pulse_law_unit
// heading and lateral distance to steering pulse and speed commands
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)                    tuser
//  s_axis    in   measured_angle 17, measured_distance 16      go_enable
//  m_axis    out  turn_command 13, speed_command 14            turn_valid
//  cfg       in   cfg_index 2, cfg_data 17 (write only)        -
//
//  one beat is taken per cycle while a stalled output does not hold the input;
//  the path is two input stages, a row of 28 arctangent cells, one angle fold
//  stage, 28 sine cells and seven stages for gain, cubic law and clamp.
//  reset empties every stage; registers return to their reset values.
//  a stalled output holds the pipeline only where stages are full, so
//  bubbles close up and input keeps flowing until the row is full.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pulse_law_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // measured_angle, measured_distance, zero fill
  input  wire logic        s_tuser,   // go_enable
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // turn_command, speed_command, zero fill
  output logic             m_tuser,   // turn_valid
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  import spl_pkg::*;

  `include "steering_pulse_law_unit_macros.svh"

  // configuration registers
  logic [11:0]        lookahead_distance;
  logic [15:0]        steer_gain;
  logic signed [16:0] angle_offset;
  logic signed [15:0] distance_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead_distance <= 12'd768;
      steer_gain         <= 16'd2458;
      angle_offset       <= '0;
      distance_offset    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: lookahead_distance <= cfg_data[11:0];
        CFG_GAIN:      steer_gain         <= cfg_data[15:0];
        CFG_ANGLE_OFS: angle_offset       <= $signed(cfg_data[16:0]);
        CFG_DIST_OFS:  distance_offset    <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // input stage: offsets added
  logic               v0, v1, v2;
  logic               r1, r2;
  logic               go0;
  logic signed [17:0] ang0;
  logic signed [16:0] dist0;
  logic [11:0]        look0;

  assign s_tready = !v0 || r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_tready) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      go0   <= s_tuser;
      ang0  <= {s_tdata[16], s_tdata[16:0]} + {angle_offset[16], angle_offset};
      dist0 <= {s_tdata[32], s_tdata[32:17]} + {distance_offset[15], distance_offset};
      look0 <= (lookahead_distance == 12'd0) ? 12'd1 : lookahead_distance;
    end
  end

  // second stage: degrees to binary angle, arctangent start vector
  cordic_t            atan_d [0:CORDIC_STEPS];
  logic               atan_v [0:CORDIC_STEPS];
  logic               atan_r [0:CORDIC_STEPS];
  cordic_t            d1;
  logic signed [50:0] degp;
  logic [28:0]        xi;

  assign degp = ang0 * $signed({1'b0, DEG_TO_TURN});
  assign xi   = 29'(look0) * LOOK_SCALE;
  assign r1   = !v1 || atan_r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v0) begin
      d1.go  <= go0;
      d1.tag <= degp[47:16];
      d1.x   <= $signed({5'b00000, xi});
      d1.y   <= $signed({{3{dist0[16]}}, dist0, 14'b0});
      d1.z   <= '0;
    end
  end

  assign atan_v[0] = v1;
  assign atan_d[0] = d1;

  // row of arctangent cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
    spl_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(i)),
      .vectoring (1'b1),
      .in_valid  (atan_v[i]),
      .in_ready  (atan_r[i]),
      .in_data   (atan_d[i]),
      .out_valid (atan_v[i+1]),
      .out_ready (atan_r[i+1]),
      .out_data  (atan_d[i+1])
    );
  end

  // fold stage: alpha into half a turn around zero
  cordic_t              sin_d [0:CORDIC_STEPS];
  logic                 sin_v [0:CORDIC_STEPS];
  logic                 sin_r [0:CORDIC_STEPS];
  cordic_t              d2;
  logic [31:0]          alpha;
  logic signed [CW-1:0] za;
  logic signed [CW-1:0] zf;

  always_comb begin
    alpha = atan_d[CORDIC_STEPS].tag + atan_d[CORDIC_STEPS].z[31:0];
    za    = $signed({{2{alpha[31]}}, alpha});
    if (za > 34'sh40000000) begin
      zf = 34'sh80000000 - za;
    end else if (za < -34'sh40000000) begin
      zf = -34'sh80000000 - za;
    end else begin
      zf = za;
    end
  end

  assign r2                   = !v2 || sin_r[0];
  assign atan_r[CORDIC_STEPS] = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= atan_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && atan_v[CORDIC_STEPS]) begin
      d2.go  <= atan_d[CORDIC_STEPS].go;
      d2.tag <= '0;
      d2.x   <= CORDIC_INV_GAIN;
      d2.y   <= '0;
      d2.z   <= zf;
    end
  end

  assign sin_v[0] = v2;
  assign sin_d[0] = d2;

  // row of sine cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin
    spl_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(i)),
      .vectoring (1'b0),
      .in_valid  (sin_v[i]),
      .in_ready  (sin_r[i]),
      .in_data   (sin_d[i]),
      .out_valid (sin_v[i+1]),
      .out_ready (sin_r[i+1]),
      .out_data  (sin_d[i+1])
    );
  end

  // gain, pulse law and clamp
  logic signed [12:0] turn;
  logic               go_out;

  spl_pulse_law u_pulse (
    .clk        (clk),
    .rst        (rst),
    .steer_gain (steer_gain),
    .in_valid   (sin_v[CORDIC_STEPS]),
    .in_ready   (sin_r[CORDIC_STEPS]),
    .in_go      (sin_d[CORDIC_STEPS].go),
    .in_sin     (sin_d[CORDIC_STEPS].y),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_turn   (turn),
    .out_go     (go_out)
  );

  // output beat
  assign m_tdata = {5'b00000, (go_out ? RUN_SPEED : 14'd0), turn};
  assign m_tuser = go_out;

  // checks
  logic signed [12:0] turn_max;

  assign turn_max = $signed(TURN_LIMIT);

  `SPL_ASSERT_NOW(a_stop_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 32'd0)
  `SPL_ASSERT_NOW(a_run_speed, clk, rst, m_tvalid && m_tuser, m_tdata[26:13] == RUN_SPEED)
  `SPL_ASSERT_NOW(a_turn_limit, clk, rst, m_tvalid, (turn <= turn_max) && (turn >= -turn_max))

endmodule

`default_nettype wire

@@ bench/steering_pulse_law_unit_chk.sv @@
// ----------------------------------------------------------------------------
// steering pulse law unit checker
// watches the input, output and register ports, predicts every output beat
// from the accepted input beat and the register values, and compares fields
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pulse_law_unit_chk
  import spl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,   // measured_angle, measured_distance, zero fill
  input  wire logic        s_tuser,   // go_enable
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // turn_command, speed_command, zero fill
  input  wire logic        m_tuser,   // turn_valid
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] turn;
    logic        turn_ok;
    logic [13:0] speed;
  } steer_cmd_t;

  localparam longint ATAN_STEP [28] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005};

  // register copies
  logic [11:0] look_reg;
  logic [15:0] gain_reg;
  logic [16:0] ang_ofs_reg;
  logic [15:0] dist_ofs_reg;

  steer_cmd_t cmd_queue[$];

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // vectoring cordic: heading of the lateral error against the lookahead
  function automatic longint error_heading(input longint xi, input longint yi);
    longint x, y, z, nx, ny;
    x = xi; y = yi; z = 0;
    for (int i = 0; i < 28; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_STEP[i];
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  // rotating cordic: sine of a binary angle, Q2.30, folded to +-90 degrees
  function automatic longint sine_q30(input logic [31:0] a);
    longint x, y, z, nx, ny;
    z = longint'(signed'(a));
    x = 652032874; y = 0;
    if (z > 64'sh40000000) z = 64'sh80000000 - z;
    else if (z < -64'sh40000000) z = -64'sh80000000 - z;
    for (int i = 0; i < 28; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_STEP[i];
      end
      x = nx; y = ny;
    end
    return y;
  endfunction

  // cubic law by horner, coefficients scaled by 1000
  function automatic longint pulse_size(input longint u);
    longint acc;
    acc = ((64'sd164977000 * u) >>> 24) - 64'sd71145760;
    acc = ((acc * u) >>> 24) + 64'sd24997900;
    acc = ((acc * u) >>> 24) + 64'sd945076;
    if (acc < 0) acc = 0;
    return acc / 1000;
  endfunction

  function automatic steer_cmd_t steer_command(input logic [16:0] angle,
                                               input logic [15:0] lat_dist,
                                               input logic        go);
    steer_cmd_t c;
    longint ang, dst, look, theta, s, w, mag, u, pulse, turn;
    longint unsigned deg_turn;
    logic [31:0] alpha;
    c = '0;
    if (!go) return c;
    ang = longint'(signed'(angle)) + longint'(signed'(ang_ofs_reg));
    dst = longint'(signed'(lat_dist)) + longint'(signed'(dist_ofs_reg));
    look = (look_reg == 0) ? 1 : longint'(look_reg);
    theta = error_heading(look * 102400, dst * 16384);
    deg_turn = (longint'(unsigned'(ang)) * 64'd3054198966) >> 16;
    alpha = 32'(deg_turn + longint'(unsigned'(theta)));
    s = sine_q30(alpha);
    w = longint'(gain_reg) * s;
    mag = (w < 0) ? -w : w;
    // deadband of 0.03 around zero
    if (mag * 100 <= (64'sd3 <<< 42)) pulse = 0;
    else begin
      u = mag >>> 18;
      if (u > (64'sd1 <<< 24)) u = 64'sd1 <<< 24;
      pulse = pulse_size(u);
      if (w < 0) pulse = -pulse;
    end
    turn = -pulse;
    if (turn > longint'(TURN_LIMIT)) turn = longint'(TURN_LIMIT);
    else if (turn < -longint'(TURN_LIMIT)) turn = -longint'(TURN_LIMIT);
    c.turn = 13'(turn);
    c.turn_ok = 1'b1;
    c.speed = RUN_SPEED;
    return c;
  endfunction

  assign pending = cmd_queue.size();

  // sample all three ports at the rising edge
  always @(posedge clk) begin
    steer_cmd_t want;
    if (rst) begin
      look_reg <= 12'd768;
      gain_reg <= 16'd2458;
      ang_ofs_reg <= '0;
      dist_ofs_reg <= '0;
      errors <= 0;
      beats_seen <= 0;
      cmd_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOOKAHEAD: look_reg <= cfg_data[11:0];
          CFG_GAIN:      gain_reg <= cfg_data[15:0];
          CFG_ANGLE_OFS: ang_ofs_reg <= cfg_data;
          CFG_DIST_OFS:  dist_ofs_reg <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        cmd_queue.push_back(steer_command(s_tdata[16:0], s_tdata[32:17], s_tuser));
      if (m_tvalid && m_tready) begin
        beats_seen <= beats_seen + 1;
        if (cmd_queue.size() == 0) report("output beat with nothing expected");
        else begin
          want = cmd_queue.pop_front();
          if (m_tdata[12:0] !== want.turn)
            report($sformatf("turn_command got %0d want %0d",
                             signed'(m_tdata[12:0]), signed'(want.turn)));
          if (m_tuser !== want.turn_ok)
            report($sformatf("turn_valid got %b want %b", m_tuser, want.turn_ok));
          if (m_tdata[26:13] !== want.speed)
            report($sformatf("speed_command got %0d want %0d",
                             m_tdata[26:13], want.speed));
          if (m_tdata[31:27] !== '0) report("tdata fill bits not zero");
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/steering_pulse_law_unit_tb.sv @@
// ----------------------------------------------------------------------------
// steering pulse law unit testbench
// drives heading and distance beats through several register settings with
// random gaps and output stalls, one long output hold; the checker predicts
// and compares every output beat
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pulse_law_unit_tb;
  import spl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // measured_angle, measured_distance, zero fill
  logic        s_tuser = 0;    // go_enable
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;        // turn_command, speed_command, zero fill
  logic        m_tuser;        // turn_valid
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int errors, pending, beats_seen, items_sent, phases_run;
  bit steady;      // no gaps or stalls in this phase
  bit hold_req;    // ask the receiver for one long hold

  steering_pulse_law_unit uut (.*);

  steering_pulse_law_unit_chk chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending, .beats_seen);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // one input beat, after a random gap
  task automatic send_beat(input logic [16:0] angle, input logic [15:0] lat_dist,
                           input logic go);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, lat_dist, angle};
    s_tuser <= go;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [11:0] look, input logic [15:0] gain,
                            input logic [16:0] aofs, input logic [15:0] dofs);
    cfg_we <= 1'b1; cfg_index <= CFG_LOOKAHEAD; cfg_data <= 17'(look);
    @(negedge clk);
    cfg_index <= CFG_GAIN; cfg_data <= 17'(gain);
    @(negedge clk);
    cfg_index <= CFG_ANGLE_OFS; cfg_data <= aofs;
    @(negedge clk);
    cfg_index <= CFG_DIST_OFS; cfg_data <= 17'(dofs);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain: all results back, then the pipeline depth again
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_beats(input int count);
    logic [16:0] a;
    logic [15:0] d;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        a = 17'($urandom); d = 16'($urandom);              // whole field range
      end else if (pick < 35) begin
        a = 17'($urandom_range(0, 1024) - 512);           // near the deadband
        d = 16'($urandom_range(0, 256) - 128);
      end else begin
        a = 17'($urandom_range(0, 92160) - 46080);
        d = 16'($urandom);
      end
      send_beat(a, d, $urandom_range(0, 99) < 88);
    end
  endtask

  // output side: random stall per beat, one long hold on request
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (1000) @(negedge clk);
        hold_req = 0;
      end
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats at reset settings: extremes, go low, zero inputs
    send_beat(17'sd46080, 16'sd0, 1);
    send_beat(-17'sd46080, 16'sd0, 1);
    send_beat(17'sd0, 16'sd0, 1);
    send_beat(17'sd0, 16'sd32767, 1);
    send_beat(17'sd0, -16'sd32768, 1);
    send_beat(17'sd46080, 16'sd32767, 1);
    send_beat(-17'sd46080, -16'sd32768, 1);
    send_beat(17'sd23040, 16'sd0, 1);       // quarter turn
    send_beat(-17'sd23040, 16'sd0, 1);
    send_beat(17'sd65535, 16'sd100, 1);     // past half a turn
    send_beat(-17'sd65536, -16'sd100, 1);
    send_beat(17'sd40, 16'sd3, 1);          // inside the deadband
    send_beat(17'sd46080, 16'sd32767, 0);   // go low
    send_beat(17'h1FFFF, 16'hFFFF, 0);
    send_beat(17'sd7680, 16'sd1600, 1);
    drain();

    // large gain, zero lookahead: saturated cubic and clamp
    write_regs(12'd0, 16'hFFFF, 17'sd46080, 16'sd32767);
    send_beat(17'sd0, 16'sd0, 1);
    send_beat(17'sd23040, -16'sd32768, 1);
    send_beat(-17'sd23040, 16'sd0, 1);
    send_beat(17'sd100, 16'sd5, 0);
    drain();

    phases_run = 2;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_regs(12'd1, 16'd0, -17'sd46080, -16'sd32768);
        1: write_regs(12'd4095, 16'hFFFF, 17'sd46080, 16'sd32767);
        2: write_regs(12'd768, 16'd2458, 17'sd0, 16'sd0);
        3: write_regs(12'd0, 16'd8000, 17'sd0, 16'sd0);
        default: write_regs(12'($urandom), 16'($urandom),
                            17'($urandom_range(0, 92160) - 46080), 16'($urandom));
      endcase
      steady = (p == 5);
      if (p == 2) hold_req = 1;
      random_beats(235);
      drain();
      steady = 0;
      phases_run++;
    end

    $display("%0d beats sent, %0d results checked over %0d register settings",
             items_sent, beats_seen, phases_run);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
